### rtl/artt_pkg.sv
// ----------------------------------------------------------------------------
// artt_pkg: shared types and constants of the ack and retransmit table
// result kinds, opcodes, entry layout and default sizes
// ----------------------------------------------------------------------------
package artt_pkg;

	localparam int TableSizeDef = 64;
	localparam int MaxMsgLenDef = 512;
	localparam logic [31:0] DefaultTtlReset = 32'd1000;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_ACK    = 2'd1;
	localparam logic [1:0] OP_SCAN   = 2'd2;
	localparam logic [1:0] OP_UNDEF  = 2'd3;

	localparam logic [3:0] K_INSERTED    = 4'd0;
	localparam logic [3:0] K_TOO_LONG    = 4'd1;
	localparam logic [3:0] K_FULL        = 4'd2;
	localparam logic [3:0] K_PREACKED    = 4'd3;
	localparam logic [3:0] K_DELIVERED   = 4'd4;
	localparam logic [3:0] K_ACK_TOO_BIG = 4'd5;
	localparam logic [3:0] K_UNKNOWN     = 4'd6;
	localparam logic [3:0] K_TIMEOUT     = 4'd7;
	localparam logic [3:0] K_RETRANSMIT  = 4'd8;

	// payload of one table entry, active bit held apart in flops
	typedef struct packed {
		logic [15:0] id;
		logic [31:0] start;
		logic [31:0] ttl;
		logic [15:0] len;
		logic        hasbuf;
		logic [15:0] cap;
		logic        preacked;
	} entry_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] id;
		logic [5:0]  slot;
		logic [15:0] len;
		logic        last;
	} result_t;

endpackage

### rtl/artt_mem.sv
// ----------------------------------------------------------------------------
// artt_mem: entry store of the tracking table
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module artt_mem
	import artt_pkg::*;
#(
	parameter int TABLE_SIZE = TableSizeDef,
	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/ack_retransmit_tracking_table.sv
// ----------------------------------------------------------------------------
// ack_retransmit_tracking_table: messages waiting for acknowledgement
// open addressed table with linear probing, ack matching and timeout scan
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | command beat: opcode in tuser, insert, ack or scan
//  m_axis   | out       | result beats, tlast on the final one of a command
//  cfg      | in        | default ttl register write
//
// one command at a time; each probe or scan step is a memory read, then
// compare and write back; an insert or ack probes from the home slot until a
// hit or TABLE_SIZE probes, then loads its beat; a too long insert skips the probe
// a scan walks all slots, holding one beat back so the last one carries
// tlast, then loads the final beat; reset clears the active bits, entry
// payload needs no clearing; a stalled m_axis holds the walk
// ----------------------------------------------------------------------------
module ack_retransmit_tracking_table
	import artt_pkg::*;
#(
	parameter int TABLE_SIZE  = TableSizeDef,
	parameter int MAX_MSG_LEN = MaxMsgLenDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// message_id[15:0], now_ms[47:16], ttl_ms[79:48], length[95:80],
	// has_response_buffer[96], response_capacity[112:97], preack[113], zero fill
	input  logic [119:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_message_id[15:0], slot[21:16], out_length[37:22], zero fill
	output logic [39:0]  m_axis_tdata,
	// kind[3:0]
	output logic [3:0]   m_axis_tuser,
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [AW:0] LastIdx = (AW+1)'(TABLE_SIZE - 1);
	// home slot by reciprocal multiplication, exact for every 16-bit id
	localparam int RecipShift = 22;
	localparam logic [21:0] RecipMul = 22'((2 ** RecipShift + TABLE_SIZE - 1) / TABLE_SIZE);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EVAL, ST_OUT} state_t;

	state_t        state_q;
	logic [31:0]   dttl_q;
	logic [TABLE_SIZE-1:0] active_q;

	// command held for the walk
	logic [1:0]  op_q;
	logic [15:0] id_q;
	logic [31:0] now_q;
	logic [31:0] ttl_q;
	logic [15:0] len_q;
	logic        hasbuf_q;
	logic [15:0] cap_q;
	logic        pre_q;

	logic [AW-1:0] addr_q;     // slot being probed
	logic [AW:0]   cnt_q;      // steps taken
	logic          hold_q;     // scan beat held back in res_q

	result_t res_q;
	result_t out_q;
	logic    ovalid_q;

	logic          we;
	entry_t        wdata, rdata;
	logic [AW-1:0] next_addr;

	assign next_addr = (addr_q == AW'(TABLE_SIZE - 1)) ? '0 : addr_q + 1'b1;

	artt_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(addr_q),
		.wdata(wdata),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// home slot of the incoming id
	logic [15:0] in_id;
	logic [37:0] home_prod;
	logic [15:0] home_quo;
	logic [15:0] home_rem;

	assign in_id     = s_axis_tdata[15:0];
	assign home_prod = {22'd0, in_id} * {16'd0, RecipMul};
	assign home_quo  = home_prod[37:22];
	assign home_rem  = in_id - home_quo * 16'(TABLE_SIZE);

	// per step decision on the entry just read
	logic        act;
	logic        hit;
	logic        emit;
	logic [3:0]  ekind;
	logic [31:0] age;
	logic        big;
	result_t     eres;

	assign act = active_q[addr_q];
	assign age = now_q - rdata.start;
	assign big = rdata.hasbuf && (len_q > rdata.cap);

	always_comb begin
		hit   = 1'b0;
		emit  = 1'b0;
		ekind = K_INSERTED;
		we    = 1'b0;
		wdata = rdata;
		unique case (op_q)
			OP_INSERT: begin
				hit = !act;
				if (hit) begin
					we    = (state_q == ST_EVAL);
					emit  = 1'b1;
					ekind = K_INSERTED;
					wdata.id       = id_q;
					wdata.start    = now_q;
					wdata.ttl      = (ttl_q == '0) ? dttl_q : ttl_q;
					wdata.len      = len_q;
					wdata.hasbuf   = hasbuf_q;
					wdata.cap      = cap_q;
					wdata.preacked = 1'b0;
				end
			end
			OP_ACK: begin
				hit = act && (rdata.id == id_q);
				if (hit) begin
					emit = 1'b1;
					if (pre_q) begin
						ekind = K_PREACKED;
						we    = (state_q == ST_EVAL);
						wdata.preacked = 1'b1;
					end else begin
						ekind = big ? K_ACK_TOO_BIG : K_DELIVERED;
					end
				end
			end
			default: begin
				if (act) begin
					if (age > rdata.ttl) begin
						emit  = 1'b1;
						ekind = K_TIMEOUT;
					end else if (!rdata.preacked) begin
						emit  = 1'b1;
						ekind = K_RETRANSMIT;
					end
				end
			end
		endcase
	end

	// result of this step; a scan reports the stored id and length
	always_comb begin
		eres.kind = ekind;
		eres.id   = (op_q == OP_SCAN) ? rdata.id : id_q;
		eres.slot = 6'(addr_q);
		eres.len  = (op_q == OP_SCAN) ? rdata.len : len_q;
		eres.last = 1'b0;
	end

	// output register handshake
	logic ofree;
	logic push;      // scan hands its held beat over before keeping a new one
	logic load;

	assign ofree = !ovalid_q || m_axis_tready;
	assign push  = (state_q == ST_EVAL) && (op_q == OP_SCAN) && emit && hold_q;
	assign load  = ofree && (push || (state_q == ST_OUT));

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dttl_q   <= DefaultTtlReset;
			active_q <= '0;
			op_q     <= OP_INSERT;
			id_q     <= '0;
			now_q    <= '0;
			ttl_q    <= '0;
			len_q    <= '0;
			hasbuf_q <= 1'b0;
			cap_q    <= '0;
			pre_q    <= 1'b0;
			cnt_q    <= '0;
			addr_q   <= '0;
			hold_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			if (cfg_we) begin
				dttl_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						op_q     <= s_axis_tuser;
						id_q     <= s_axis_tdata[15:0];
						now_q    <= s_axis_tdata[47:16];
						ttl_q    <= s_axis_tdata[79:48];
						len_q    <= s_axis_tdata[95:80];
						hasbuf_q <= s_axis_tdata[96];
						cap_q    <= s_axis_tdata[112:97];
						pre_q    <= s_axis_tdata[113];
						cnt_q    <= '0;
						hold_q   <= 1'b0;
						addr_q   <= (s_axis_tuser == OP_SCAN) ? '0 : AW'(home_rem);
						priority if (s_axis_tuser == OP_INSERT &&
							s_axis_tdata[95:80] > 16'(MAX_MSG_LEN)) begin
							res_q <= '{K_TOO_LONG, s_axis_tdata[15:0], 6'd0,
								s_axis_tdata[95:80], 1'b1};
							state_q <= ST_OUT;
						end else if (s_axis_tuser != OP_UNDEF) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (op_q == OP_SCAN) begin
						// a new beat waits while the held one cannot move on
						if (!push || ofree) begin
							if (emit) begin
								res_q  <= eres;
								hold_q <= 1'b1;
								if (ekind == K_TIMEOUT) begin
									active_q[addr_q] <= 1'b0;
								end
							end
							if (cnt_q == LastIdx) begin
								// the held beat, if any, is the last one
								state_q <= (emit || hold_q) ? ST_OUT : ST_IDLE;
							end else begin
								cnt_q   <= cnt_q + 1'b1;
								addr_q  <= next_addr;
								state_q <= ST_READ;
							end
						end
					end else if (emit) begin
						// probe ends on a hit
						res_q <= eres;
						if (op_q == OP_INSERT) begin
							active_q[addr_q] <= 1'b1;
						end else if (!pre_q) begin
							active_q[addr_q] <= 1'b0;
						end
						state_q <= ST_OUT;
					end else if (cnt_q == LastIdx) begin
						res_q   <= '{(op_q == OP_INSERT) ? K_FULL : K_UNKNOWN, id_q, 6'd0,
							len_q, 1'b1};
						state_q <= ST_OUT;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						addr_q  <= next_addr;
						state_q <= ST_READ;
					end
				end
				ST_OUT: begin
					// final beat waits until the output register is free
					if (ofree) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// output register: tlast only on the beat loaded from ST_OUT
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			out_q    <= '0;
		end else begin
			ovalid_q <= load || (ovalid_q && !m_axis_tready);
			if (load) begin
				out_q <= '{res_q.kind, res_q.id, res_q.slot, res_q.len, (state_q == ST_OUT)};
			end
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {2'b00, out_q.len, out_q.slot, out_q.id};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

endmodule

### rtl/artt_checker.sv
// ----------------------------------------------------------------------------
// artt_checker: port level checks of the tracking table
// ----------------------------------------------------------------------------
module artt_checker
	import artt_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [39:0]  m_axis_tdata,
	input logic [3:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// kind stays within the defined codes
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= K_RETRANSMIT)
		else $error("undefined result kind");

	// an accepted command other than OP_UNDEF is not followed by another in the next cycle
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_UNDEF |=> !s_axis_tready)
		else $error("command taken during a walk");

	// single result kinds always close their command
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == K_TOO_LONG || m_axis_tuser == K_FULL ||
		m_axis_tuser == K_UNKNOWN || m_axis_tuser == K_INSERTED) |-> m_axis_tlast)
		else $error("single result without tlast");

endmodule

bind ack_retransmit_tracking_table artt_checker u_artt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
